>>> rtl/hcmm_pkg.sv
// ----------------------------------------------------------------------------
// hcmm_pkg: memory map decoder shared definitions
// Target codes, address constants and the decode record that passes
// between the decoder and the top level.
// ----------------------------------------------------------------------------
package hcmm_pkg;

  localparam int unsigned WramAddrW = 15;
  localparam int unsigned HramAddrW = 7;

  localparam logic [15:0] ADDR_BOOT_END   = 16'h0100;
  localparam logic [15:0] ADDR_XBOOT_LO   = 16'h0200;
  localparam logic [15:0] ADDR_XBOOT_END  = 16'h0900;
  localparam logic [15:0] ADDR_VRAM_BASE  = 16'h8000;
  localparam logic [15:0] ADDR_CRAM_BASE  = 16'hA000;
  localparam logic [15:0] ADDR_WRAM_BASE  = 16'hC000;
  localparam logic [15:0] ADDR_OAM_BASE   = 16'hFE00;
  localparam logic [15:0] ADDR_OAM_END    = 16'hFEA0;
  localparam logic [15:0] ADDR_IO_BASE    = 16'hFF00;
  localparam logic [15:0] ADDR_HRAM_BASE  = 16'hFF80;
  localparam logic [15:0] ADDR_IE         = 16'hFFFF;

  localparam logic [15:0] REG_JOYPAD      = 16'hFF00;
  localparam logic [15:0] REG_SB          = 16'hFF01;
  localparam logic [15:0] REG_SC          = 16'hFF02;
  localparam logic [15:0] REG_TIMER_LO    = 16'hFF04;
  localparam logic [15:0] REG_TIMER_HI    = 16'hFF07;
  localparam logic [15:0] REG_IF          = 16'hFF0F;
  localparam logic [15:0] REG_AUDIO_LO    = 16'hFF10;
  localparam logic [15:0] REG_AUDIO_HI    = 16'hFF3F;
  localparam logic [15:0] REG_VIDEO_LO    = 16'hFF40;
  localparam logic [15:0] REG_VIDEO_HI    = 16'hFF4B;
  localparam logic [15:0] REG_DMA         = 16'hFF46;
  localparam logic [15:0] REG_SPEED       = 16'hFF4D;
  localparam logic [15:0] REG_VBANK       = 16'hFF4F;
  localparam logic [15:0] REG_BOOT_OFF    = 16'hFF50;
  localparam logic [15:0] REG_HDMA_LO     = 16'hFF51;
  localparam logic [15:0] REG_HDMA_HI     = 16'hFF55;
  localparam logic [15:0] REG_VCOL_LO     = 16'hFF68;
  localparam logic [15:0] REG_VCOL_HI     = 16'hFF6B;
  localparam logic [15:0] REG_WBANK       = 16'hFF70;

  localparam logic [7:0]  BYTE_OPEN       = 8'hFF;
  localparam logic [7:0]  VBANK_FILL      = 8'hFE;
  localparam logic [2:0]  WBANK_RESET     = 3'd1;

  typedef enum logic [4:0] {
    TGT_LOCAL   = 5'd0,
    TGT_BOOT    = 5'd1,
    TGT_CROM    = 5'd2,
    TGT_VRAM    = 5'd3,
    TGT_CRAM    = 5'd4,
    TGT_OAM     = 5'd5,
    TGT_JOYPAD  = 5'd6,
    TGT_IFLAG   = 5'd7,
    TGT_DMA     = 5'd8,
    TGT_TIMER   = 5'd9,
    TGT_VIDEO   = 5'd10,
    TGT_AUDIO   = 5'd11,
    TGT_IENABLE = 5'd12,
    TGT_HDMA    = 5'd13,
    TGT_VBANK   = 5'd14,
    TGT_SPEED   = 5'd15,
    TGT_NONE    = 5'd16
  } tgt_e;

  typedef enum logic [1:0] {
    SRC_REG  = 2'd0,
    SRC_WRAM = 2'd1,
    SRC_HRAM = 2'd2
  } src_e;

  typedef struct packed {
    tgt_e                 target;
    logic [15:0]          offset;
    logic [7:0]           fwd;
    logic [7:0]           fill;
    logic [7:0]           rdata;
    logic                 is_local;
    src_e                 src;
    logic                 wram_we;
    logic                 wram_re;
    logic [WramAddrW-1:0] wram_addr;
    logic                 hram_we;
    logic                 hram_re;
    logic [HramAddrW-1:0] hram_addr;
    logic                 sb_we;
    logic                 sc_we;
    logic                 boot_off_set;
    logic                 bank_we;
    logic [2:0]           bank_wdata;
  } dec_t;

endpackage

>>> rtl/handheld_console_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// handheld_console_memory_map_decoder: 16-bit bus memory map decoder
// A transaction is held in the decode stage register, then its result in the output register.
// Throughput is one transaction per cycle while results are taken; each
// transaction makes at most one access to a single-port work-RAM or high-RAM memory.
// Reset clears the control state, sets the work bank to 1 and leaves RAM
// contents undefined; there is no clearing pass.
// ----------------------------------------------------------------------------
module handheld_console_memory_map_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address[15:0], write_data[23:16], dma_active[24], from_dma[25],
  // speed_mode[26], speed_pending[27], zero fill[31:28]
  input  logic [31:0] s_axis_tdata,
  // op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // target[4:0], target_offset[20:5], forward_data[28:21],
  // read_fill_mask[36:29], read_data[44:37], zero fill[47:45]
  output logic [47:0] m_axis_tdata,
  // is_local[0]
  output logic        m_axis_tuser
);

  import hcmm_pkg::*;

  dec_t       dec;
  logic       accept;
  logic       out_load;
  logic [7:0] wram_rdata;
  logic [7:0] hram_rdata;
  logic [7:0] rdata_sel;

  logic       color_mode_q, color_mode_d;
  logic [2:0] work_bank_q, work_bank_d;
  logic       boot_off_q, boot_off_d;
  logic [7:0] serial_byte_q, serial_byte_d;
  logic [7:0] serial_ctrl_q, serial_ctrl_d;
  logic       pend_q, pend_d;
  dec_t       res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic [44:0] out_data_q, out_data_d;
  logic       out_local_q, out_local_d;

  hcmm_decode u_decode (
    .op_i            (s_axis_tuser),
    .addr_i          (s_axis_tdata[15:0]),
    .wdata_i         (s_axis_tdata[23:16]),
    .dma_active_i    (s_axis_tdata[24]),
    .from_dma_i      (s_axis_tdata[25]),
    .speed_mode_i    (s_axis_tdata[26]),
    .speed_pending_i (s_axis_tdata[27]),
    .color_mode_i    (color_mode_q),
    .boot_off_i      (boot_off_q),
    .work_bank_i     (work_bank_q),
    .serial_byte_i   (serial_byte_q),
    .serial_ctrl_i   (serial_ctrl_q),
    .dec_o           (dec)
  );

  hcmm_ram #(.AddrW(WramAddrW)) u_wram (
    .clk_i   (clk_i),
    .we_i    (accept && dec.wram_we),
    .re_i    (accept && dec.wram_re),
    .addr_i  (dec.wram_addr),
    .wdata_i (s_axis_tdata[23:16]),
    .rdata_o (wram_rdata)
  );

  hcmm_ram #(.AddrW(HramAddrW)) u_hram (
    .clk_i   (clk_i),
    .we_i    (accept && dec.hram_we),
    .re_i    (accept && dec.hram_re),
    .addr_i  (dec.hram_addr),
    .wdata_i (s_axis_tdata[23:16]),
    .rdata_o (hram_rdata)
  );

  assign out_load      = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || out_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (res_q.src)
      SRC_WRAM: rdata_sel = wram_rdata;
      SRC_HRAM: rdata_sel = hram_rdata;
      default:  rdata_sel = res_q.rdata;
    endcase
  end

  always_comb begin
    color_mode_d  = cfg_we_i ? cfg_wdata_i : color_mode_q;
    work_bank_d   = (accept && dec.bank_we) ? dec.bank_wdata : work_bank_q;
    boot_off_d    = boot_off_q || (accept && dec.boot_off_set);
    serial_byte_d = (accept && dec.sb_we) ? s_axis_tdata[23:16] : serial_byte_q;
    serial_ctrl_d = (accept && dec.sc_we) ? s_axis_tdata[23:16] : serial_ctrl_q;
    pend_d        = accept ? 1'b1 : (out_load ? 1'b0 : pend_q);
    res_d         = accept ? dec : res_q;
    out_valid_d   = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    out_data_d    = out_load ? {rdata_sel, res_q.fill, res_q.fwd, res_q.offset,
                                res_q.target} : out_data_q;
    out_local_d   = out_load ? res_q.is_local : out_local_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= 1'b0;
      work_bank_q   <= WBANK_RESET;
      boot_off_q    <= 1'b0;
      serial_byte_q <= 8'd0;
      serial_ctrl_q <= 8'd0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      color_mode_q  <= color_mode_d;
      work_bank_q   <= work_bank_d;
      boot_off_q    <= boot_off_d;
      serial_byte_q <= serial_byte_d;
      serial_ctrl_q <= serial_ctrl_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    out_data_q  <= out_data_d;
    out_local_q <= out_local_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_data_q};
  assign m_axis_tuser  = out_local_q;

  a_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_bank_q != 3'd0)
    else $error("Work bank select holds zero.");

  a_local_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[4:0] == TGT_LOCAL)
    else $error("Local answer reported with a forwarded target.");

  a_stage_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_load |-> !s_axis_tready)
    else $error("Transaction accepted while the decode stage is stalled.");

  a_boot_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dec.boot_off_set |=> boot_off_q)
    else $error("Boot overlay not disabled after its register write.");

endmodule

>>> rtl/hcmm_ram.sv
// ----------------------------------------------------------------------------
// hcmm_ram: single-port synchronous byte memory
// One address per cycle, written, read or both, with registered read data.
// ----------------------------------------------------------------------------
module hcmm_ram #(
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [2**AddrW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hcmm_decode.sv
// ----------------------------------------------------------------------------
// hcmm_decode: address decoder
// Maps one bus transaction onto a target, memory accesses and register
// updates, using the current bank, overlay, serial and colour-mode state.
// ----------------------------------------------------------------------------
module hcmm_decode (
  input  logic          op_i,
  input  logic [15:0]   addr_i,
  input  logic [7:0]    wdata_i,
  input  logic          dma_active_i,
  input  logic          from_dma_i,
  input  logic          speed_mode_i,
  input  logic          speed_pending_i,
  input  logic          color_mode_i,
  input  logic          boot_off_i,
  input  logic [2:0]    work_bank_i,
  input  logic [7:0]    serial_byte_i,
  input  logic [7:0]    serial_ctrl_i,
  output hcmm_pkg::dec_t dec_o
);

  import hcmm_pkg::*;

  dec_t d;
  logic blocked;
  logic bank0;
  logic is_hdma;
  logic is_vcol;
  logic is_timer;
  logic is_video;
  logic is_audio;

  always_comb begin
    blocked  = !from_dma_i && dma_active_i && (addr_i != REG_DMA) &&
               (addr_i < ADDR_HRAM_BASE);
    bank0    = (addr_i[15:12] == 4'hC) || (addr_i[15:12] == 4'hE);
    is_hdma  = (addr_i >= REG_HDMA_LO) && (addr_i <= REG_HDMA_HI);
    is_vcol  = (addr_i >= REG_VCOL_LO) && (addr_i <= REG_VCOL_HI);
    is_timer = (addr_i >= REG_TIMER_LO) && (addr_i <= REG_TIMER_HI);
    is_video = (addr_i >= REG_VIDEO_LO) && (addr_i <= REG_VIDEO_HI);
    is_audio = (addr_i >= REG_AUDIO_LO) && (addr_i <= REG_AUDIO_HI);

    d            = '0;
    d.target     = TGT_NONE;
    d.offset     = addr_i;
    d.src        = SRC_REG;
    d.wram_addr  = {(bank0 ? 3'd0 : work_bank_i), addr_i[11:0]};
    d.hram_addr  = addr_i[HramAddrW-1:0];
    d.bank_wdata = (wdata_i[2:0] == 3'd0) ? WBANK_RESET : wdata_i[2:0];

    if (blocked) begin
      if (!op_i) begin
        d.target   = TGT_LOCAL;
        d.rdata    = BYTE_OPEN;
        d.is_local = 1'b1;
      end
    end else if (!op_i) begin
      if (!boot_off_i && ((addr_i < ADDR_BOOT_END) || (color_mode_i &&
          (addr_i >= ADDR_XBOOT_LO) && (addr_i < ADDR_XBOOT_END)))) begin
        d.target = TGT_BOOT;
      end else if (addr_i < ADDR_VRAM_BASE) begin
        d.target = TGT_CROM;
      end else if (addr_i < ADDR_CRAM_BASE) begin
        d.target = TGT_VRAM;
        d.offset = addr_i - ADDR_VRAM_BASE;
      end else if (addr_i < ADDR_WRAM_BASE) begin
        d.target = TGT_CRAM;
        d.offset = addr_i - ADDR_CRAM_BASE;
      end else if (addr_i < ADDR_OAM_BASE) begin
        d.target   = TGT_LOCAL;
        d.is_local = 1'b1;
        d.src      = SRC_WRAM;
        d.wram_re  = 1'b1;
      end else if (addr_i < ADDR_OAM_END) begin
        d.target = TGT_OAM;
        d.offset = addr_i - ADDR_OAM_BASE;
      end else if (addr_i < ADDR_IO_BASE) begin
        d.target   = TGT_LOCAL;
        d.rdata    = BYTE_OPEN;
        d.is_local = 1'b1;
      end else if (addr_i < ADDR_HRAM_BASE) begin
        if (addr_i == REG_JOYPAD) begin
          d.target = TGT_JOYPAD;
        end else if (addr_i == REG_SB) begin
          d.target   = TGT_LOCAL;
          d.rdata    = serial_byte_i;
          d.is_local = 1'b1;
        end else if (addr_i == REG_SC) begin
          d.target   = TGT_LOCAL;
          d.rdata    = serial_ctrl_i;
          d.is_local = 1'b1;
        end else if (addr_i == REG_IF) begin
          d.target = TGT_IFLAG;
        end else if (addr_i == REG_DMA) begin
          d.target = TGT_DMA;
        end else if (color_mode_i && (addr_i == REG_SPEED)) begin
          d.target   = TGT_LOCAL;
          d.rdata    = {speed_mode_i, 6'b111111, speed_pending_i};
          d.is_local = 1'b1;
        end else if (color_mode_i && is_hdma) begin
          d.target = TGT_HDMA;
        end else if (color_mode_i && (addr_i == REG_WBANK)) begin
          d.target   = TGT_LOCAL;
          d.rdata    = {5'b11111, work_bank_i};
          d.is_local = 1'b1;
        end else if (color_mode_i && (addr_i == REG_VBANK)) begin
          d.target = TGT_VBANK;
          d.fill   = VBANK_FILL;
        end else if (color_mode_i && is_vcol) begin
          d.target = TGT_VIDEO;
        end else if (is_timer) begin
          d.target = TGT_TIMER;
        end else if (is_video) begin
          d.target = TGT_VIDEO;
        end else if (is_audio) begin
          d.target = TGT_AUDIO;
        end else begin
          d.target   = TGT_LOCAL;
          d.rdata    = BYTE_OPEN;
          d.is_local = 1'b1;
        end
      end else if (addr_i < ADDR_IE) begin
        d.target   = TGT_LOCAL;
        d.is_local = 1'b1;
        d.src      = SRC_HRAM;
        d.hram_re  = 1'b1;
      end else begin
        d.target = TGT_IENABLE;
      end
    end else begin
      d.fwd = wdata_i;
      if (addr_i < ADDR_VRAM_BASE) begin
        d.target = TGT_CROM;
      end else if (addr_i < ADDR_CRAM_BASE) begin
        d.target = TGT_VRAM;
        d.offset = addr_i - ADDR_VRAM_BASE;
      end else if (addr_i < ADDR_WRAM_BASE) begin
        d.target = TGT_CRAM;
        d.offset = addr_i - ADDR_CRAM_BASE;
      end else if (addr_i < ADDR_OAM_BASE) begin
        d.target  = TGT_LOCAL;
        d.wram_we = 1'b1;
      end else if (addr_i < ADDR_OAM_END) begin
        d.target = TGT_OAM;
        d.offset = addr_i - ADDR_OAM_BASE;
      end else if (addr_i < ADDR_IO_BASE) begin
        d.target = TGT_NONE;
      end else if (addr_i < ADDR_HRAM_BASE) begin
        if (addr_i == REG_JOYPAD) begin
          d.target = TGT_JOYPAD;
        end else if (addr_i == REG_SB) begin
          d.target = TGT_LOCAL;
          d.sb_we  = 1'b1;
        end else if (addr_i == REG_SC) begin
          d.target = TGT_LOCAL;
          d.sc_we  = 1'b1;
        end else if (addr_i == REG_IF) begin
          d.target = TGT_IFLAG;
        end else if (addr_i == REG_DMA) begin
          d.target = TGT_DMA;
        end else if (addr_i == REG_BOOT_OFF) begin
          d.target       = TGT_LOCAL;
          d.boot_off_set = 1'b1;
        end else if (color_mode_i && (addr_i == REG_SPEED)) begin
          d.target = TGT_SPEED;
          d.fwd    = {7'd0, wdata_i[0]};
        end else if (color_mode_i && is_hdma) begin
          d.target = TGT_HDMA;
        end else if (color_mode_i && (addr_i == REG_WBANK)) begin
          d.target  = TGT_LOCAL;
          d.bank_we = 1'b1;
        end else if (color_mode_i && (addr_i == REG_VBANK)) begin
          d.target = TGT_VBANK;
          d.fwd    = {7'd0, wdata_i[0]};
        end else if (color_mode_i && is_vcol) begin
          d.target = TGT_VIDEO;
        end else if (is_timer) begin
          d.target = TGT_TIMER;
        end else if (is_video) begin
          d.target = TGT_VIDEO;
        end else if (is_audio) begin
          d.target = TGT_AUDIO;
        end else begin
          d.target = TGT_NONE;
        end
      end else if (addr_i < ADDR_IE) begin
        d.target  = TGT_LOCAL;
        d.hram_we = 1'b1;
      end else begin
        d.target = TGT_IENABLE;
      end
      if ((d.target == TGT_LOCAL) || (d.target == TGT_NONE)) begin
        d.fwd = 8'd0;
      end
    end
  end

  assign dec_o = d;

endmodule
